// ===== rtl/nft_pkg.sv =====
// ----------------------------------------------------------------------------
// nft_pkg
// Shared types, tag codes and decode functions for the HTML namespace
// feedback tracker.
// ----------------------------------------------------------------------------
package nft_pkg;

  // Default and maximum number of namespace stack entries.
  localparam int unsigned StackDepthDefault = 32;

  // Token kinds as delivered by the tokenizer.
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_SPARE = 2'd3
  } kind_e;

  // Namespaces held on the stack.
  typedef enum logic [1:0] {
    NS_HTML = 2'd0,
    NS_SVG  = 2'd1,
    NS_MATH = 2'd2,
    NS_NONE = 2'd3
  } ns_e;

  // Tokenizer mode requests.
  typedef enum logic [2:0] {
    MODE_KEEP      = 3'd0,
    MODE_RCDATA    = 3'd1,
    MODE_PLAINTEXT = 3'd2,
    MODE_SCRIPT    = 3'd3,
    MODE_RAWTEXT   = 3'd4,
    MODE_ERROR     = 3'd5
  } mode_e;

  // Error reports.
  typedef enum logic [1:0] {
    ERR_NONE          = 2'd0,
    ERR_FOREIGN_OVFL  = 2'd1,
    ERR_HTML_OVFL     = 2'd2
  } err_e;

  // Stack update chosen for one token.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_POP  = 2'd2
  } act_e;

  // Tag codes.
  localparam logic [6:0] TagTextarea      = 7'd1;
  localparam logic [6:0] TagTitle         = 7'd2;
  localparam logic [6:0] TagPlaintext     = 7'd3;
  localparam logic [6:0] TagScript        = 7'd4;
  localparam logic [6:0] TagStyle         = 7'd5;
  localparam logic [6:0] TagNoscript      = 7'd10;
  localparam logic [6:0] TagBase          = 7'd11;
  localparam logic [6:0] TagMeta          = 7'd15;
  localparam logic [6:0] TagBr            = 7'd17;
  localparam logic [6:0] TagEmbed         = 7'd18;
  localparam logic [6:0] TagImg           = 7'd19;
  localparam logic [6:0] TagHr            = 7'd26;
  localparam logic [6:0] TagMath          = 7'd27;
  localparam logic [6:0] TagSvg           = 7'd28;
  localparam logic [6:0] TagFrame         = 7'd30;
  localparam logic [6:0] TagB             = 7'd31;
  localparam logic [6:0] TagVar           = 7'd63;
  localparam logic [6:0] TagFont          = 7'd64;
  localparam logic [6:0] TagMi            = 7'd65;
  localparam logic [6:0] TagMtext         = 7'd69;
  localparam logic [6:0] TagDesc          = 7'd70;
  localparam logic [6:0] TagForeignObject = 7'd71;
  localparam logic [6:0] TagImage         = 7'd72;

  // One result transaction.
  typedef struct packed {
    mode_e tokenizer_mode;
    logic  cdata_permitted;
    logic  trailing_solidus_error;
    logic  rewrite_to_img;
    err_e  error_code;
    ns_e   current_namespace;
  } out_t;

  // Tokenizer mode that an HTML start tag selects.
  function automatic mode_e mode_for(logic [6:0] t);
    mode_e m;
    m = MODE_KEEP;
    if (t == TagTextarea || t == TagTitle) begin
      m = MODE_RCDATA;
    end else if (t == TagPlaintext) begin
      m = MODE_PLAINTEXT;
    end else if (t == TagScript) begin
      m = MODE_SCRIPT;
    end else if (t >= TagStyle && t <= TagNoscript) begin
      m = MODE_RAWTEXT;
    end
    return m;
  endfunction

  // Void elements take no end tag.
  function automatic logic is_void(logic [6:0] t);
    return (t >= TagBase) && (t <= TagFrame);
  endfunction

  // Start tags that leave foreign content.
  function automatic logic breaks_out(logic [6:0] t, logic heading, logic font_attr);
    logic r;
    if ((t >= TagB && t <= TagVar) || t == TagMeta || t == TagBr ||
        t == TagEmbed || t == TagImg || t == TagHr) begin
      r = 1'b1;
    end else if (t == TagFont) begin
      r = font_attr;
    end else begin
      r = heading;
    end
    return r;
  endfunction

  // Elements inside which HTML content resumes.
  function automatic logic integration_point(ns_e ns, logic [6:0] t, logic is_start,
                                             logic annot, logic enc);
    logic r;
    r = 1'b0;
    if (ns == NS_MATH) begin
      r = (t >= TagMi && t <= TagMtext) || (is_start && annot && enc);
    end else if (ns == NS_SVG) begin
      r = (t == TagDesc) || (t == TagTitle) || (t == TagForeignObject);
    end
    return r;
  endfunction

endpackage

// ===== rtl/nft_if.sv =====
// ----------------------------------------------------------------------------
// nft_if
// Valid/ready channels for tokens entering and results leaving the tracker.
// ----------------------------------------------------------------------------
interface nft_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [6:0] tag_code;
  logic       ends_with_slash;
  logic       heading_name;
  logic       font_presentation_attr;
  logic       name_is_annotation_xml;
  logic       annotation_html_encoding;

  modport source (
    output valid, token_kind, tag_code, ends_with_slash, heading_name,
           font_presentation_attr, name_is_annotation_xml, annotation_html_encoding,
    input  ready
  );
  modport sink (
    input  valid, token_kind, tag_code, ends_with_slash, heading_name,
           font_presentation_attr, name_is_annotation_xml, annotation_html_encoding,
    output ready
  );
endinterface

interface nft_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tokenizer_mode;
  logic       cdata_permitted;
  logic       trailing_solidus_error;
  logic       rewrite_to_img;
  logic [1:0] error_code;
  logic [1:0] current_namespace;

  modport source (
    output valid, tokenizer_mode, cdata_permitted, trailing_solidus_error,
           rewrite_to_img, error_code, current_namespace,
    input  ready
  );
  modport sink (
    input  valid, tokenizer_mode, cdata_permitted, trailing_solidus_error,
           rewrite_to_img, error_code, current_namespace,
    output ready
  );
endinterface

// ===== rtl/nft_ram.sv =====
// ----------------------------------------------------------------------------
// nft_ram
// Simple dual-port namespace memory: one write and one registered read per
// cycle. Holds the stack entries below the two cached top entries.
// ----------------------------------------------------------------------------
module nft_ram #(
  parameter int unsigned Depth = nft_pkg::StackDepthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  nft_pkg::ns_e     wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output nft_pkg::ns_e     rdata_o
);
  import nft_pkg::*;

  ns_e mem_q [Depth];
  ns_e rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/nft_out_buf.sv =====
// ----------------------------------------------------------------------------
// nft_out_buf
// Output register with a skid stage, so that a new transaction can be taken
// in the same cycle in which a stalled result waits.
// ----------------------------------------------------------------------------
module nft_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nft_pkg::out_t data_i,
  output logic          ready_o,
  nft_out_if.source     out_o
);
  import nft_pkg::*;

  out_t main_q, skid_q;
  logic main_v_q, skid_v_q;
  logic drain;

  assign ready_o = !skid_v_q;
  assign drain   = !main_v_q || out_o.ready;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (drain) begin
      main_v_q <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (drain) begin
      main_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign out_o.valid                  = main_v_q;
  assign out_o.tokenizer_mode         = main_q.tokenizer_mode;
  assign out_o.cdata_permitted        = main_q.cdata_permitted;
  assign out_o.trailing_solidus_error = main_q.trailing_solidus_error;
  assign out_o.rewrite_to_img         = main_q.rewrite_to_img;
  assign out_o.error_code             = main_q.error_code;
  assign out_o.current_namespace      = main_q.current_namespace;

endmodule

// ===== rtl/html_namespace_feedback_tracker.sv =====
// ----------------------------------------------------------------------------
// html_namespace_feedback_tracker
// Tracks the HTML / SVG / MathML namespace stack of a token stream and tells
// the tokenizer how to read what follows.
// ----------------------------------------------------------------------------
// The tracker takes one token per clock cycle unless its output buffer stalls,
// and returns exactly one result per token through an output register
// backed by a skid stage. The stack top and the entry under it live in
// registers; deeper entries live in a memory with one write and one
// registered read port, which is read every cycle at the entry that the next
// pop would need, so that pops and pushes may follow each other in
// consecutive cycles. The memory is not cleared after reset and needs no
// clearing pass: an entry is always written before it can be read.
module html_namespace_feedback_tracker #(
  parameter int unsigned STACK_DEPTH = nft_pkg::StackDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  nft_in_if.sink    in_i,
  nft_out_if.source out_o
);
  import nft_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Cached stack entries, fill count and memory forwarding.
  ns_e             top_q, top_d;
  ns_e             second_q, second_d;
  logic [CntW-1:0] count_q, count_d;
  logic            fwd_q;
  ns_e             fwd_data_q;

  // Memory port signals.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [CntW-1:0]  waddr_full, raddr_full;
  ns_e              ram_rdata, below_second;

  // Step decode signals.
  logic      accept, buf_ready, full, has_second;
  kind_e     kind;
  logic [6:0] tag;
  act_e      act;
  ns_e       push_ns, top_after;
  mode_e     mode;
  err_e      err;
  logic      solidus, rewrite, delayed;
  logic [6:0] eff_tag;
  out_t      result;

  assign in_i.ready  = buf_ready;
  assign accept      = in_i.valid && buf_ready;
  assign kind        = kind_e'(in_i.token_kind);
  assign tag         = in_i.tag_code;
  assign full        = (count_q == CntW'(STACK_DEPTH));
  assign has_second  = (count_q > CntW'(1));
  assign below_second = fwd_q ? fwd_data_q : ram_rdata;

  // Per-token decode: stack action and result fields.
  always_comb begin
    act       = ACT_NONE;
    push_ns   = NS_HTML;
    mode      = MODE_KEEP;
    err       = ERR_NONE;
    rewrite   = 1'b0;
    delayed   = 1'b0;
    eff_tag   = tag;
    top_after = top_q;
    solidus   = 1'b0;
    if (kind == KIND_START) begin
      if (tag == TagSvg || tag == TagMath) begin
        if (full) begin
          mode = MODE_ERROR;
          err  = ERR_FOREIGN_OVFL;
        end else begin
          act     = ACT_PUSH;
          push_ns = (tag == TagSvg) ? NS_SVG : NS_MATH;
        end
      end else if (top_q != NS_HTML) begin
        if (breaks_out(tag, in_i.heading_name, in_i.font_presentation_attr)) begin
          act = ACT_POP;
        end else begin
          delayed = !in_i.ends_with_slash &&
                    integration_point(top_q, tag, 1'b1, in_i.name_is_annotation_xml,
                                      in_i.annotation_html_encoding);
        end
      end else begin
        if (tag == TagImage) begin
          eff_tag = TagImg;
          rewrite = 1'b1;
        end
        mode = mode_for(tag);
      end
      // Namespace after the tag's own handling decides the solidus error.
      if (act == ACT_PUSH) begin
        top_after = push_ns;
      end else if (act == ACT_POP && has_second) begin
        top_after = second_q;
      end
      solidus = (top_after == NS_HTML) && in_i.ends_with_slash && !is_void(eff_tag);
      // HTML push after an integration point.
      if (delayed) begin
        if (full) begin
          mode = MODE_ERROR;
          err  = ERR_HTML_OVFL;
        end else begin
          act     = ACT_PUSH;
          push_ns = NS_HTML;
        end
      end
    end else if (kind == KIND_END) begin
      if (top_q != NS_HTML) begin
        if ((top_q == NS_SVG && tag == TagSvg) || (top_q == NS_MATH && tag == TagMath)) begin
          act = ACT_POP;
        end
      end else if (has_second &&
                   integration_point(second_q, tag, 1'b0, in_i.name_is_annotation_xml,
                                     in_i.annotation_html_encoding)) begin
        act = ACT_POP;
      end
    end
  end

  // Stack update; a pop from a single entry is ignored.
  always_comb begin
    top_d    = top_q;
    second_d = second_q;
    count_d  = count_q;
    ram_we   = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_PUSH: begin
          top_d    = push_ns;
          second_d = top_q;
          count_d  = count_q + CntW'(1);
          ram_we   = has_second;
        end
        ACT_POP: begin
          if (has_second) begin
            top_d    = second_q;
            second_d = below_second;
            count_d  = count_q - CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Old second entry spills to memory at count-2; prefetch entry count_d-3.
  assign waddr_full = count_q - CntW'(2);
  assign raddr_full = count_d - CntW'(3);
  assign ram_waddr  = waddr_full[AddrW-1:0];
  assign ram_raddr  = raddr_full[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= NS_HTML;
      count_q <= CntW'(1);
      fwd_q   <= 1'b0;
    end else begin
      top_q   <= top_d;
      count_q <= count_d;
      fwd_q   <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    second_q   <= second_d;
    fwd_data_q <= second_q;
  end

  nft_ram #(
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(second_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result assembly from the namespace after the step.
  always_comb begin
    result.tokenizer_mode         = mode;
    result.cdata_permitted        = (top_d != NS_HTML);
    result.trailing_solidus_error = solidus;
    result.rewrite_to_img         = rewrite;
    result.error_code             = err;
    result.current_namespace      = top_d;
  end

  nft_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (result),
    .ready_o(buf_ready),
    .out_o  (out_o)
  );

endmodule

// ===== dv/html_namespace_feedback_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_namespace_feedback_tracker_test
// Self-checking bench for the namespace tracker. A stimulus table with
// hand-checked results comes first. Then random token streams that alternate
// between nesting deeper and unwinding drive the stack into overflow and back.
// Every result transaction is checked field by field against its hand-checked
// result or a behavioral tracker. The sender and the receiver idle and stall at
// random in several phases, and one long receiver hold-off backs the tracker up.
// ----------------------------------------------------------------------------
module html_namespace_feedback_tracker_test;
  import nft_pkg::*;

  localparam int unsigned STACK_DEPTH = StackDepthDefault;
  localparam int unsigned PhaseItems  = 270;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DirRows     = 27;

  // One token as the tokenizer delivers it.
  typedef struct packed {
    kind_e      kind;
    logic [6:0] tag;
    logic       sc;
    logic       heading;
    logic       font_attr;
    logic       annot;
    logic       enc;
  } token_t;

  // A token with an optional hand-written result and a repeat count.
  typedef struct packed {
    token_t     tk;
    logic [5:0] reps;
    logic       typed;
    out_t       want;
  } step_row_t;

  // Traffic shapes of the run.
  typedef enum logic [2:0] {
    PH_STREAM,
    PH_SPARSE,
    PH_STALL,
    PH_BOTH,
    PH_BACKPRESSURE
  } tb_phase_e;

  // Token classes for the random stream.
  typedef enum logic [2:0] {
    PICK_ROOT,
    PICK_ISLAND,
    PICK_BREAKOUT,
    PICK_CLOSE_ROOT,
    PICK_CLOSE_ISLAND,
    PICK_HTML,
    PICK_NOISE
  } pick_e;

  localparam out_t HTML_IDLE = '{MODE_KEEP, 1'b0, 1'b0, 1'b0, ERR_NONE, NS_HTML};

  localparam step_row_t DIRECTED [DirRows] = '{
    // Tokens other than tags change nothing.
    '{'{KIND_OTHER, 7'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1, HTML_IDLE},
    '{'{KIND_SPARE, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 6'd1, 1'b1, HTML_IDLE},
    // Tokenizer modes selected by HTML start tags.
    '{'{KIND_START, TagTextarea, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_RCDATA, 1'b0, 1'b0, 1'b0, ERR_NONE, NS_HTML}},
    '{'{KIND_START, TagTitle, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    '{'{KIND_START, TagPlaintext, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_PLAINTEXT, 1'b0, 1'b0, 1'b0, ERR_NONE, NS_HTML}},
    '{'{KIND_START, TagScript, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_SCRIPT, 1'b0, 1'b1, 1'b0, ERR_NONE, NS_HTML}},
    '{'{KIND_START, TagStyle, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_RAWTEXT, 1'b0, 1'b0, 1'b0, ERR_NONE, NS_HTML}},
    '{'{KIND_START, TagNoscript, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    // Image is renamed to img, which is void.
    '{'{KIND_START, TagImage, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_KEEP, 1'b0, 1'b0, 1'b1, ERR_NONE, NS_HTML}},
    '{'{KIND_START, TagBr, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1, HTML_IDLE},
    // An unlisted self-closing tag is a trailing-solidus error.
    '{'{KIND_START, 7'd127, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 6'd1, 1'b1,
      '{MODE_KEEP, 1'b0, 1'b1, 1'b0, ERR_NONE, NS_HTML}},
    // A stray end tag on the bottom level does not pop.
    '{'{KIND_END, TagSvg, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1, HTML_IDLE},
    // Into svg, through an integration point and back.
    '{'{KIND_START, TagSvg, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_KEEP, 1'b1, 1'b0, 1'b0, ERR_NONE, NS_SVG}},
    '{'{KIND_START, TagForeignObject, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      HTML_IDLE},
    '{'{KIND_END, TagForeignObject, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_KEEP, 1'b1, 1'b0, 1'b0, ERR_NONE, NS_SVG}},
    '{'{KIND_START, TagMath, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_KEEP, 1'b1, 1'b0, 1'b0, ERR_NONE, NS_MATH}},
    // annotation-xml counts on start tags only.
    '{'{KIND_START, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 6'd1, 1'b0, HTML_IDLE},
    '{'{KIND_END, 7'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 6'd1, 1'b0, HTML_IDLE},
    '{'{KIND_END, TagMi, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    // font breaks out only with a presentation attribute; headings always.
    '{'{KIND_START, TagFont, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    '{'{KIND_START, TagFont, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    '{'{KIND_START, 7'd0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    // Fill the stack, then overflow on both kinds of push.
    '{'{KIND_START, TagSvg, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd31, 1'b0, HTML_IDLE},
    '{'{KIND_START, TagMath, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_ERROR, 1'b1, 1'b0, 1'b0, ERR_FOREIGN_OVFL, NS_SVG}},
    '{'{KIND_START, TagDesc, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b1,
      '{MODE_ERROR, 1'b1, 1'b0, 1'b0, ERR_HTML_OVFL, NS_SVG}},
    '{'{KIND_START, TagTitle, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd1, 1'b0, HTML_IDLE},
    // Unwind everything with breakout tags.
    '{'{KIND_START, TagB, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 6'd31, 1'b0, HTML_IDLE}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  nft_in_if  tok_if ();
  nft_out_if res_if ();

  tb_phase_e phase = PH_BOTH;

  // Behavioral namespace stack and run statistics.
  ns_e         model_ns [STACK_DEPTH];
  int unsigned ns_depth;
  int unsigned deepest;
  int unsigned foreign_overflows;
  int unsigned html_overflows;
  int unsigned tokens_taken;
  int unsigned results_checked;
  int unsigned failures;

  step_row_t offered_tokens[$];
  out_t      expected_results[$];

  html_namespace_feedback_tracker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tok_if),
    .out_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  // True where a tag in the given namespace lets HTML content resume.
  function automatic logic opens_html_island(ns_e ns, logic [6:0] tag, logic annot_html);
    return (ns == NS_MATH && ((tag inside {[TagMi:TagMtext]}) || annot_html)) ||
           (ns == NS_SVG && (tag inside {TagDesc, TagTitle, TagForeignObject}));
  endfunction

  // Applies one token to the behavioral stack and returns its result.
  function automatic out_t track_token(token_t tk);
    out_t       r;
    ns_e        top;
    logic [6:0] seen_as;
    logic       reenter_html;
    logic       leaves_foreign;
    r            = HTML_IDLE;
    seen_as      = tk.tag;
    reenter_html = 1'b0;
    top          = model_ns[ns_depth-1];
    if (tk.kind == KIND_START) begin
      if (tk.tag == TagSvg || tk.tag == TagMath) begin
        // A foreign root opens a new level, unless the stack is full.
        if (ns_depth < STACK_DEPTH) begin
          model_ns[ns_depth] = (tk.tag == TagSvg) ? NS_SVG : NS_MATH;
          ns_depth++;
        end else begin
          r.tokenizer_mode = MODE_ERROR;
          r.error_code     = ERR_FOREIGN_OVFL;
          foreign_overflows++;
        end
      end else if (top != NS_HTML) begin
        leaves_foreign = (tk.tag inside {[TagB:TagVar], TagMeta, TagBr, TagEmbed, TagImg,
                                         TagHr}) ||
                         ((tk.tag == TagFont) ? tk.font_attr : tk.heading);
        if (leaves_foreign) begin
          if (ns_depth > 1) begin
            ns_depth--;
          end
        end else begin
          reenter_html = !tk.sc && opens_html_island(top, tk.tag, tk.annot && tk.enc);
        end
      end else begin
        // HTML start tag: image rewrite and tokenizer mode.
        if (tk.tag == TagImage) begin
          seen_as          = TagImg;
          r.rewrite_to_img = 1'b1;
        end
        if (tk.tag inside {TagTextarea, TagTitle}) begin
          r.tokenizer_mode = MODE_RCDATA;
        end else if (tk.tag == TagPlaintext) begin
          r.tokenizer_mode = MODE_PLAINTEXT;
        end else if (tk.tag == TagScript) begin
          r.tokenizer_mode = MODE_SCRIPT;
        end else if (tk.tag inside {[TagStyle:TagNoscript]}) begin
          r.tokenizer_mode = MODE_RAWTEXT;
        end
      end
      // The solidus check sees the stack before the delayed HTML push.
      r.trailing_solidus_error = (model_ns[ns_depth-1] == NS_HTML) && tk.sc &&
                                 !(seen_as inside {[TagBase:TagFrame]});
      if (reenter_html) begin
        if (ns_depth < STACK_DEPTH) begin
          model_ns[ns_depth] = NS_HTML;
          ns_depth++;
        end else begin
          r.tokenizer_mode = MODE_ERROR;
          r.error_code     = ERR_HTML_OVFL;
          html_overflows++;
        end
      end
    end else if (tk.kind == KIND_END) begin
      // End tags close the matching root, or the island just below the top.
      if (top != NS_HTML) begin
        if ((top == NS_SVG && tk.tag == TagSvg) || (top == NS_MATH && tk.tag == TagMath)) begin
          ns_depth--;
        end
      end else if (ns_depth >= 2 && opens_html_island(model_ns[ns_depth-2], tk.tag, 1'b0)) begin
        ns_depth--;
      end
    end
    if (ns_depth > deepest) begin
      deepest = ns_depth;
    end
    r.current_namespace = model_ns[ns_depth-1];
    r.cdata_permitted   = (r.current_namespace != NS_HTML);
    return r;
  endfunction

  // Random token, weighted toward nesting deeper or toward unwinding.
  function automatic token_t pick_token(logic diving);
    token_t      tk;
    pick_e       what;
    int unsigned roll;
    tk.kind      = KIND_START;
    tk.tag       = 7'($urandom_range(0, 127));
    tk.sc        = ($urandom_range(0, 3) == 0);
    tk.heading   = ($urandom_range(0, 7) == 0);
    tk.font_attr = 1'($urandom_range(0, 1));
    tk.annot     = ($urandom_range(0, 7) == 0);
    tk.enc       = 1'($urandom_range(0, 1));
    roll         = $urandom_range(0, 99);
    if (diving) begin
      what = (roll < 45) ? PICK_ROOT : (roll < 65) ? PICK_ISLAND : (roll < 75) ? PICK_HTML :
             (roll < 80) ? PICK_CLOSE_ROOT : (roll < 85) ? PICK_CLOSE_ISLAND :
             (roll < 88) ? PICK_BREAKOUT : PICK_NOISE;
    end else begin
      what = (roll < 35) ? PICK_BREAKOUT : (roll < 55) ? PICK_CLOSE_ROOT :
             (roll < 75) ? PICK_CLOSE_ISLAND : (roll < 83) ? PICK_HTML :
             (roll < 86) ? PICK_ROOT : (roll < 88) ? PICK_ISLAND : PICK_NOISE;
    end
    case (what)
      PICK_ROOT: begin
        tk.tag = $urandom_range(0, 1) ? TagSvg : TagMath;
      end
      PICK_ISLAND, PICK_CLOSE_ISLAND: begin
        tk.sc = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
          0: tk.tag = TagMi + 7'($urandom_range(0, 4));
          1: tk.tag = TagDesc;
          2: tk.tag = TagTitle;
          default: begin
            tk.tag = (what == PICK_ISLAND) ? 7'd0 : TagForeignObject;
            if (what == PICK_ISLAND) begin
              tk.annot = 1'b1;
              tk.enc   = 1'b1;
            end
          end
        endcase
        if (what == PICK_CLOSE_ISLAND) begin
          tk.kind = KIND_END;
        end
      end
      PICK_BREAKOUT: begin
        case ($urandom_range(0, 6))
          0, 1: tk.tag = TagB + 7'($urandom_range(0, 32));
          2: tk.tag = TagMeta;
          3: tk.tag = $urandom_range(0, 1) ? TagBr : TagEmbed;
          4: tk.tag = $urandom_range(0, 1) ? TagImg : TagHr;
          5: begin
            tk.tag       = TagFont;
            tk.font_attr = 1'b1;
          end
          default: begin
            tk.tag     = 7'd0;
            tk.heading = 1'b1;
          end
        endcase
      end
      PICK_CLOSE_ROOT: begin
        tk.kind = KIND_END;
        tk.tag  = $urandom_range(0, 1) ? TagSvg : TagMath;
      end
      PICK_NOISE: begin
        tk.kind    = kind_e'($urandom_range(0, 3));
        tk.sc      = 1'($urandom_range(0, 1));
        tk.heading = 1'($urandom_range(0, 1));
        tk.annot   = 1'($urandom_range(0, 1));
      end
      default: ;
    endcase
    return tk;
  endfunction

  // Offers one token after a random gap and waits for the transaction.
  task automatic offer_token(token_t tk, logic typed, out_t want);
    int unsigned gap_pct;
    gap_pct = (phase == PH_SPARSE) ? 70 : (phase == PH_BOTH) ? 24 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      tok_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    offered_tokens.push_back('{tk, 6'd1, typed, want});
    tok_if.valid                    <= 1'b1;
    tok_if.token_kind               <= tk.kind;
    tok_if.tag_code                 <= tk.tag;
    tok_if.ends_with_slash          <= tk.sc;
    tok_if.heading_name             <= tk.heading;
    tok_if.font_presentation_attr   <= tk.font_attr;
    tok_if.name_is_annotation_xml   <= tk.annot;
    tok_if.annotation_html_encoding <= tk.enc;
    do begin
      @(posedge clk_i);
    end while (tok_if.ready !== 1'b1);
  endtask

  task automatic note_mismatch(string field, logic [2:0] want, logic [2:0] got);
    if (failures < 40) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
    failures++;
  endtask

  // Token monitor: each accepted transaction updates the tracker model.
  always @(posedge clk_i) begin : take_token
    step_row_t rec;
    out_t      r;
    if (rst_ni && tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
      rec = offered_tokens.pop_front();
      r   = track_token(rec.tk);
      expected_results.push_back(rec.typed ? rec.want : r);
      tokens_taken++;
    end
  end

  // Result monitor: compare with the oldest expectation.
  always @(posedge clk_i) begin : check_result
    out_t got;
    out_t want;
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got = out_t'({res_if.tokenizer_mode, res_if.cdata_permitted,
                    res_if.trailing_solidus_error, res_if.rewrite_to_img,
                    res_if.error_code, res_if.current_namespace});
      if (expected_results.size() == 0) begin
        $display("%0t ns: result transaction with no token pending, got %h", $time, got);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.tokenizer_mode !== want.tokenizer_mode) begin
          note_mismatch("tokenizer_mode", want.tokenizer_mode, got.tokenizer_mode);
        end
        if (got.cdata_permitted !== want.cdata_permitted) begin
          note_mismatch("cdata_permitted", 3'(want.cdata_permitted),
                        3'(got.cdata_permitted));
        end
        if (got.trailing_solidus_error !== want.trailing_solidus_error) begin
          note_mismatch("trailing_solidus_error", 3'(want.trailing_solidus_error),
                        3'(got.trailing_solidus_error));
        end
        if (got.rewrite_to_img !== want.rewrite_to_img) begin
          note_mismatch("rewrite_to_img", 3'(want.rewrite_to_img), 3'(got.rewrite_to_img));
        end
        if (got.error_code !== want.error_code) begin
          note_mismatch("error_code", 3'(want.error_code), 3'(got.error_code));
        end
        if (got.current_namespace !== want.current_namespace) begin
          note_mismatch("current_namespace", 3'(want.current_namespace),
                        3'(got.current_namespace));
        end
      end
    end
  end

  // Result sink: random stalls by phase, plus one long hold-off.
  initial begin : result_sink
    int unsigned hold_left;
    logic        hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PH_BACKPRESSURE && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >=
                         ((phase == PH_STALL) ? 70 : (phase == PH_BOTH) ? 24 : 0));
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Reset, directed table, random phases and drain.
  initial begin : stimulus
    logic        diving;
    int unsigned drain_cycles;
    ns_depth          = 1;
    model_ns[0]       = NS_HTML;
    deepest           = 1;
    foreign_overflows = 0;
    html_overflows    = 0;
    tokens_taken      = 0;
    results_checked   = 0;
    failures          = 0;
    diving            = 1'b1;
    tok_if.valid                    <= 1'b0;
    tok_if.token_kind               <= KIND_OTHER;
    tok_if.tag_code                 <= 7'd0;
    tok_if.ends_with_slash          <= 1'b0;
    tok_if.heading_name             <= 1'b0;
    tok_if.font_presentation_attr   <= 1'b0;
    tok_if.name_is_annotation_xml   <= 1'b0;
    tok_if.annotation_html_encoding <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < DirRows; row++) begin
      for (int k = 0; k < DIRECTED[row].reps; k++) begin
        offer_token(DIRECTED[row].tk, DIRECTED[row].typed, DIRECTED[row].want);
      end
    end

    for (int p = PH_STREAM; p <= PH_BACKPRESSURE; p++) begin
      phase = tb_phase_e'(p);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 59) == 0) begin
          diving = !diving;
        end
        offer_token(pick_token(diving), 1'b0, HTML_IDLE);
      end
    end
    tok_if.valid <= 1'b0;

    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (5) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_results.size());
      failures++;
    end

    $display("Checked %0d results for %0d tokens; the namespace stack reached depth %0d of %0d.",
             results_checked, tokens_taken, deepest, STACK_DEPTH);
    $display("Overflow was hit %0d times on svg/math pushes and %0d times on HTML pushes.",
             foreign_overflows, html_overflows);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
